### hw/rtl/rpu_trailer_and_nal_escape_defines.svh
// Assertion macros shared by the RTL of the trailer and escape block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RPU_TRAILER_AND_NAL_ESCAPE_DEFINES_SVH
`define RPU_TRAILER_AND_NAL_ESCAPE_DEFINES_SVH

// Same-cycle implication.
`define RPTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rpte_pkg.sv
`default_nettype none

package rpte_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 32;

  localparam logic [ByteW-1:0] NalPrefixByte  = 8'd25;
  localparam logic [ByteW-1:0] TerminatorByte = 8'h80;
  localparam logic [ByteW-1:0] EscapeByte     = 8'h03;
  localparam logic [CrcW-1:0]  CrcPoly        = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0]  CrcInit        = 32'hFFFF_FFFF;

  function automatic logic [CrcW-1:0] crc_update(logic [CrcW-1:0] crc,
                                                 logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {data, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      c = c[CrcW-1] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rpte_in_if.sv
`default_nettype none

interface rpte_in_if;
  logic                       valid;
  logic                       ready;
  logic [rpte_pkg::ByteW-1:0] payload_byte;
  logic                       payload_last;

  modport source (output valid, output payload_byte, output payload_last, input ready);
  modport sink   (input valid, input payload_byte, input payload_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rpte_out_if.sv
`default_nettype none

interface rpte_out_if;
  logic                       valid;
  logic                       ready;
  logic [rpte_pkg::ByteW-1:0] out_byte;
  logic                       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rpu_trailer_and_nal_escape.sv
// Packs a byte-aligned metadata payload into an escaped NAL unit.
// payload_i takes one payload byte per transfer with a last flag. nal_o gives
// the unit one byte per transfer: the prefix byte 25 before the first payload
// byte, every payload byte, and after the last one the CRC-32/MPEG-2 of the
// payload, most significant byte first, then the terminator 0x80 with out_last
// set. All but the prefix pass through emulation prevention, so an inserted
// 0x03 adds one byte.
// A payload transfer is held in an item register and drained into the output
// register at one byte per cycle while nal_o is not stalled. An item makes one
// output byte for a plain payload byte, plus one for a prefix, plus five
// for the trailer of a last byte, plus one for each inserted 0x03.
// The next payload transfer is taken in the cycle the current item hands over
// its final byte, so a stream without escapes runs at one byte per cycle while
// nal_o is ready.
// When the receiver stalls, the output register holds its byte and the item
// register fills; payload_i then drops ready until the output drains.
// Reset clears the CRC to all ones, the zero run and the prefix flag, and
// empties both registers; the first byte after reset opens a new unit.
`include "rpu_trailer_and_nal_escape_defines.svh"
`default_nettype none

module rpu_trailer_and_nal_escape (
  input  wire         clk_i,
  input  wire         rst_ni,
  rpte_in_if.sink     payload_i,
  rpte_out_if.source  nal_o
);

  typedef enum logic [2:0] {
    PhPrefix,
    PhData,
    PhCrc3,
    PhCrc2,
    PhCrc1,
    PhCrc0,
    PhTerm
  } phase_e;

  logic [rpte_pkg::CrcW-1:0]  crc_q, crc_d;
  logic                       prefix_sent_q, prefix_sent_d;
  logic                       busy_q, busy_d;
  phase_e                     phase_q, phase_d;
  logic                       esc_done_q, esc_done_d;
  logic [1:0]                 zcnt_q, zcnt_d;
  logic [rpte_pkg::ByteW-1:0] item_byte_q;
  logic                       item_last_q;
  logic [rpte_pkg::CrcW-1:0]  item_crc_q;
  logic                       out_valid_q, out_valid_d;
  logic [rpte_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;

  logic [rpte_pkg::CrcW-1:0]  crc_next;
  logic [rpte_pkg::ByteW-1:0] cur_byte;
  logic                       cur_zero;
  logic                       esc_need;
  logic                       adv;
  logic                       finish;
  logic                       in_xfer;

  assign crc_next = rpte_pkg::crc_update(crc_q, payload_i.payload_byte);

  always_comb begin
    case (phase_q)
      PhPrefix: cur_byte = rpte_pkg::NalPrefixByte;
      PhData:   cur_byte = item_byte_q;
      PhCrc3:   cur_byte = item_crc_q[31:24];
      PhCrc2:   cur_byte = item_crc_q[23:16];
      PhCrc1:   cur_byte = item_crc_q[15:8];
      PhCrc0:   cur_byte = item_crc_q[7:0];
      PhTerm:   cur_byte = rpte_pkg::TerminatorByte;
      default:  cur_byte = rpte_pkg::TerminatorByte;
    endcase
  end

  assign cur_zero = (cur_byte == '0);
  assign esc_need = (phase_q != PhPrefix) && zcnt_q[1] && (cur_byte[7:2] == '0) &&
                    !esc_done_q;
  assign adv      = busy_q && (!out_valid_q || nal_o.ready);
  assign finish   = !esc_need && (((phase_q == PhData) && !item_last_q) ||
                                  (phase_q == PhTerm));

  assign payload_i.ready = !busy_q || (adv && finish);
  assign in_xfer         = payload_i.valid && payload_i.ready;

  always_comb begin
    crc_d         = crc_q;
    prefix_sent_d = prefix_sent_q;
    busy_d        = busy_q;
    phase_d       = phase_q;
    esc_done_d    = esc_done_q;
    zcnt_d        = zcnt_q;
    out_valid_d   = out_valid_q;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;

    if (adv) begin
      out_valid_d = 1'b1;
      if (esc_need) begin
        out_byte_d = rpte_pkg::EscapeByte;
        out_last_d = 1'b0;
        esc_done_d = 1'b1;
      end else begin
        out_byte_d = cur_byte;
        out_last_d = (phase_q == PhTerm);
        esc_done_d = 1'b0;
        if ((phase_q == PhPrefix) || (phase_q == PhTerm)) begin
          zcnt_d = 2'd0;
        end else if (!zcnt_q[1]) begin
          zcnt_d = cur_zero ? zcnt_q + 2'd1 : 2'd0;
        end else begin
          zcnt_d = cur_zero ? 2'd1 : 2'd0;
        end
        case (phase_q)
          PhPrefix: phase_d = PhData;
          PhData:   phase_d = PhCrc3;
          PhCrc3:   phase_d = PhCrc2;
          PhCrc2:   phase_d = PhCrc1;
          PhCrc1:   phase_d = PhCrc0;
          PhCrc0:   phase_d = PhTerm;
          default:  phase_d = PhTerm;
        endcase
        if (finish) begin
          busy_d = 1'b0;
        end
      end
    end else if (nal_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (in_xfer) begin
      busy_d        = 1'b1;
      esc_done_d    = 1'b0;
      phase_d       = prefix_sent_q ? PhData : PhPrefix;
      prefix_sent_d = !payload_i.payload_last;
      crc_d         = payload_i.payload_last ? rpte_pkg::CrcInit : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q         <= rpte_pkg::CrcInit;
      prefix_sent_q <= 1'b0;
      busy_q        <= 1'b0;
      phase_q       <= PhPrefix;
      esc_done_q    <= 1'b0;
      zcnt_q        <= 2'd0;
      out_valid_q   <= 1'b0;
    end else begin
      crc_q         <= crc_d;
      prefix_sent_q <= prefix_sent_d;
      busy_q        <= busy_d;
      phase_q       <= phase_d;
      esc_done_q    <= esc_done_d;
      zcnt_q        <= zcnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_byte_q <= payload_i.payload_byte;
      item_last_q <= payload_i.payload_last;
      item_crc_q  <= crc_next;
    end
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign nal_o.valid    = out_valid_q;
  assign nal_o.out_byte = out_byte_q;
  assign nal_o.out_last = out_last_q;

  `RPTE_ASSERT_IMP(a_zcnt_range, 1'b1, zcnt_q != 2'd3, "Zero run count out of range.")
  `RPTE_ASSERT_NXT(a_xfer_busy, in_xfer, busy_q, "Accepted item not held.")
  `RPTE_ASSERT_NXT(a_term_clears, adv && !esc_need && (phase_q == PhTerm) && !in_xfer,
                   (zcnt_q == 2'd0) && !prefix_sent_q, "Unit end did not clear state.")
  `RPTE_ASSERT_IMP(a_last_is_term, out_valid_q && out_last_q,
                   out_byte_q == rpte_pkg::TerminatorByte, "Last byte is not the terminator.")

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RandomItems = 250;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned HoldAfter   = 200;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DirCount    = 22;

  typedef struct packed {
    logic [rpte_pkg::ByteW-1:0] data;
    logic                       last;
  } nal_byte_t;

  // A row with n_typed set carries its own expected bytes, all with out_last low.
  typedef struct packed {
    logic [rpte_pkg::ByteW-1:0] data;
    logic                       last;
    logic [1:0]                 n_typed;
    logic [rpte_pkg::ByteW-1:0] t0;
    logic [rpte_pkg::ByteW-1:0] t1;
  } dir_row_t;

  localparam dir_row_t DirRows [0:DirCount-1] = '{
    '{8'h00, 1'b0, 2'd2, rpte_pkg::NalPrefixByte, 8'h00},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h03, 1'b0, 2'd2, rpte_pkg::EscapeByte, 8'h03},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h00, 1'b0, 2'd2, rpte_pkg::EscapeByte, 8'h00},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h04, 1'b0, 2'd1, 8'h04, 8'h00},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h01, 1'b0, 2'd2, rpte_pkg::EscapeByte, 8'h01},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h02, 1'b0, 2'd2, rpte_pkg::EscapeByte, 8'h02},
    '{8'hFF, 1'b1, 2'd0, 8'h00, 8'h00},
    '{8'h80, 1'b1, 2'd0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 2'd2, rpte_pkg::NalPrefixByte, 8'h00},
    '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{8'h55, 1'b0, 2'd2, rpte_pkg::NalPrefixByte, 8'h55},
    '{8'hAA, 1'b1, 2'd0, 8'h00, 8'h00},
    '{8'hFF, 1'b1, 2'd0, 8'h00, 8'h00}
  };

  logic clk_i;
  logic rst_ni;

  rpte_in_if  payload_if ();
  rpte_out_if nal_if ();

  rpu_trailer_and_nal_escape u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .payload_i (payload_if),
    .nal_o     (nal_if)
  );

  logic [rpte_pkg::CrcW-1:0] unit_crc;
  logic [1:0]                zrun_cnt;
  logic                      prefix_out;

  nal_byte_t   step_bytes [$];
  nal_byte_t   pending_bytes [$];
  int unsigned mismatches;
  int unsigned out_xfers;
  int unsigned cycles;
  logic        calm;
  logic        hold_done;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [rpte_pkg::CrcW-1:0] crc_next(logic [rpte_pkg::CrcW-1:0] crc,
                                                         logic [rpte_pkg::ByteW-1:0] b);
    logic [rpte_pkg::CrcW-1:0] c;
    logic                      fb;
    c = crc;
    for (int i = rpte_pkg::ByteW - 1; i >= 0; i--) begin
      fb = c[rpte_pkg::CrcW-1] ^ b[i];
      c = {c[rpte_pkg::CrcW-2:0], 1'b0} ^ (fb ? rpte_pkg::CrcPoly : '0);
    end
    return c;
  endfunction

  function automatic void escape_out(logic [rpte_pkg::ByteW-1:0] b, logic l);
    if (zrun_cnt < 2'd2) begin
      zrun_cnt = (b == '0) ? zrun_cnt + 2'd1 : 2'd0;
    end else begin
      if (b[rpte_pkg::ByteW-1:2] == '0) step_bytes.push_back('{rpte_pkg::EscapeByte, 1'b0});
      zrun_cnt = (b == '0) ? 2'd1 : 2'd0;
    end
    step_bytes.push_back('{b, l});
  endfunction

  function automatic void clear_unit();
    unit_crc   = rpte_pkg::CrcInit;
    zrun_cnt   = 2'd0;
    prefix_out = 1'b0;
  endfunction

  function automatic void pack_byte(logic [rpte_pkg::ByteW-1:0] b, logic l);
    step_bytes.delete();
    if (!prefix_out) begin
      step_bytes.push_back('{rpte_pkg::NalPrefixByte, 1'b0});
      prefix_out = 1'b1;
      zrun_cnt   = 2'd0;
    end
    unit_crc = crc_next(unit_crc, b);
    escape_out(b, 1'b0);
    if (l) begin
      for (int k = 3; k >= 0; k--) escape_out(unit_crc[8*k +: 8], 1'b0);
      escape_out(rpte_pkg::TerminatorByte, 1'b1);
      clear_unit();
    end
  endfunction

  task automatic send_byte(input logic [rpte_pkg::ByteW-1:0] b, input logic l);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      payload_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    payload_if.valid        <= 1'b1;
    payload_if.payload_byte <= b;
    payload_if.payload_last <= l;
    @(posedge clk_i);
    while (!payload_if.ready) @(posedge clk_i);
    pack_byte(b, l);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL rpu_trailer_and_nal_escape");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    nal_byte_t want;
    if (rst_ni && nal_if.valid && nal_if.ready) begin
      out_xfers = out_xfers + 1;
      if (pending_bytes.size() == 0) begin
        $display("%0t: expected no transfer, got byte %h last %b",
                 $time, nal_if.out_byte, nal_if.out_last);
        mismatches = mismatches + 1;
      end else begin
        want = pending_bytes.pop_front();
        if (nal_if.out_byte !== want.data) begin
          $display("%0t: out_byte expected %h, got %h", $time, want.data, nal_if.out_byte);
          mismatches = mismatches + 1;
        end
        if (nal_if.out_last !== want.last) begin
          $display("%0t: out_last expected %b, got %b", $time, want.last, nal_if.out_last);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    nal_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!hold_done && out_xfers >= HoldAfter) begin
        hold_done = 1'b1;
        nal_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      nal_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        nal_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [rpte_pkg::ByteW-1:0] b;
    rst_ni                   = 1'b0;
    cycles                   = 0;
    mismatches               = 0;
    out_xfers                = 0;
    calm                     = 1'b0;
    hold_done                = 1'b0;
    payload_if.valid        <= 1'b0;
    payload_if.payload_byte <= '0;
    payload_if.payload_last <= 1'b0;
    clear_unit();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      send_byte(DirRows[i].data, DirRows[i].last);
      if (DirRows[i].n_typed == 2'd0) begin
        foreach (step_bytes[j]) pending_bytes.push_back(step_bytes[j]);
      end else begin
        pending_bytes.push_back('{DirRows[i].t0, 1'b0});
        if (DirRows[i].n_typed == 2'd2) pending_bytes.push_back('{DirRows[i].t1, 1'b0});
      end
    end

    // Payload bytes lean toward zero and small values so that zero runs
    // and escapes show up often, also inside the CRC trailer.
    sent = 0;
    while (sent < RandomItems) begin
      calm = (sent >= 80 && sent < 130);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 35) b = 8'h00;
        else if (r < 55) b = 8'($urandom_range(1, 3));
        else b = 8'($urandom_range(0, 255));
        send_byte(b, j == len - 1);
        foreach (step_bytes[k]) pending_bytes.push_back(step_bytes[k]);
        sent++;
      end
    end
    calm = 1'b0;
    payload_if.valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS rpu_trailer_and_nal_escape");
    end else begin
      $display("FAIL rpu_trailer_and_nal_escape");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/rpte_pkg.sv
hw/rtl/rpte_in_if.sv
hw/rtl/rpte_out_if.sv
hw/rtl/rpu_trailer_and_nal_escape.sv
sim/testbench.sv
